// File: design/clcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD write sequencer package
// Shared types, constants and the init ROM of the 4-bit LCD sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int DELAY_BITS   = 16;
	localparam int INIT_ENTRIES = 8;
	localparam int STEP_BITS    = $clog2(INIT_ENTRIES + 1);
	localparam int QDEPTH       = 2;
	localparam int QPTR_BITS    = $clog2(QDEPTH);
	localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

	localparam logic [15:0] POWER_ON_WAIT_RESET = 16'd1500;

	// Request selector codes on the func port.
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_INIT  = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_INIT,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data_byte;
		logic        reg_select;
		logic [15:0] delay_after_us;
	} cmd_t;

	typedef struct packed {
		logic [3:0] lcd_nibble;
		logic       lcd_rs;
		logic       lcd_enable;
		logic       busy_res;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic [7:0]  rom_byte;
		logic        lone;
		logic [15:0] delay;
	} rom_entry_t;

	// Clamp a 16-bit microsecond count to the delay counter range.
	function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [15:0] v);
		logic [32:0] lim;
		logic [32:0] wide;
		begin
			lim  = (33'd1 << DELAY_BITS) - 33'd1;
			wide = {17'd0, v};
			if (wide > lim) begin
				sat_delay = lim[DELAY_BITS-1:0];
			end else begin
				sat_delay = wide[DELAY_BITS-1:0];
			end
		end
	endfunction

	// Init ROM: two lone 0x3 nibbles, then the configuration bytes.
	function automatic rom_entry_t init_rom(input logic [3:0] idx);
		rom_entry_t e;
		begin
			case (idx)
				4'd0:    e = '{rom_byte: 8'h03, lone: 1'b1, delay: 16'd4100};
				4'd1:    e = '{rom_byte: 8'h03, lone: 1'b1, delay: 16'd100};
				4'd2:    e = '{rom_byte: 8'h32, lone: 1'b0, delay: 16'd40};
				4'd3:    e = '{rom_byte: 8'h28, lone: 1'b0, delay: 16'd40};
				4'd4:    e = '{rom_byte: 8'h08, lone: 1'b0, delay: 16'd40};
				4'd5:    e = '{rom_byte: 8'h01, lone: 1'b0, delay: 16'd1640};
				4'd6:    e = '{rom_byte: 8'h06, lone: 1'b0, delay: 16'd40};
				default: e = '{rom_byte: 8'h0C, lone: 1'b0, delay: 16'd40};
			endcase
			init_rom = e;
		end
	endfunction

endpackage
`default_nettype wire

// File: design/clcd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD sequencer front end
// Accepts requests, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
module clcd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [1:0]    func,
	input  wire logic [7:0]    data_byte,
	input  wire logic          reg_select,
	input  wire logic [15:0]   delay_after_us,
	output logic               cmd_valid,
	output clcd_pkg::cmd_t     cmd,
	input  wire logic          cmd_take
);
	import clcd_pkg::*;

	cmd_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	cmd_t                 new_cmd;
	logic                 do_push;
	logic                 do_pop;

	always_comb begin
		new_cmd.data_byte      = data_byte;
		new_cmd.reg_select     = reg_select;
		new_cmd.delay_after_us = delay_after_us;
		case (func)
			FUNC_TICK:  new_cmd.kind = CMD_TICK;
			FUNC_WRITE: new_cmd.kind = CMD_WRITE;
			FUNC_INIT:  new_cmd.kind = CMD_INIT;
			default:    new_cmd.kind = CMD_NOP;
		endcase
	end

	assign full      = (cnt_q == QCNT_BITS'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/clcd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD sequencer back end
// Runs the nibble timing and init sequence and queues one result per request.
// ----------------------------------------------------------------------------
module clcd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_wdata,
	input  wire logic          cmd_valid,
	input  wire clcd_pkg::cmd_t cmd,
	output logic               cmd_take,
	output logic               empty,
	input  wire logic          pop,
	output clcd_pkg::result_t  res
);
	import clcd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POWER,
		PH_SETUP,
		PH_EHIGH,
		PH_ELOW,
		PH_DELAY
	} phase_t;

	phase_t                phase_q, n_phase;
	logic [15:0]           power_wait_q;
	logic [7:0]            byte_q, n_byte;
	logic                  rs_q, n_rs;
	logic [DELAY_BITS-1:0] delay_q, n_delay;
	logic                  low_q, n_low;
	logic [DELAY_BITS-1:0] wait_q, n_wait;
	logic [STEP_BITS-1:0]  step_q, n_step;
	logic [5:0]            pin_q, n_pin;
	logic                  n_rej;
	logic                  busy;
	logic                  done;
	logic                  load;
	logic                  drive;
	rom_entry_t            rom_e;
	logic [7:0]            ld_byte;
	logic                  ld_rs;
	logic [DELAY_BITS-1:0] ld_delay;
	logic                  ld_lone;
	logic [3:0]            rom_idx;
	result_t               new_res;

	result_t               omem_q [QDEPTH];
	logic [QPTR_BITS-1:0]  owr_q;
	logic [QPTR_BITS-1:0]  ord_q;
	logic [QCNT_BITS-1:0]  ocnt_q;
	logic                  opop;

	assign busy     = (phase_q != PH_IDLE);
	assign cmd_take = cmd_valid && (ocnt_q != QCNT_BITS'(QDEPTH));

	// The ROM index is zero when init starts and the current step otherwise.
	assign rom_idx = (cmd.kind == CMD_TICK && phase_q != PH_POWER) ? step_q[3:0] : 4'd0;
	assign rom_e   = init_rom(rom_idx);

	always_comb begin
		n_phase  = phase_q;
		n_byte   = byte_q;
		n_rs     = rs_q;
		n_delay  = delay_q;
		n_low    = low_q;
		n_wait   = wait_q;
		n_step   = step_q;
		n_pin    = pin_q;
		n_rej    = 1'b0;
		done     = 1'b0;
		load     = 1'b0;
		drive    = 1'b0;
		ld_byte  = rom_e.rom_byte;
		ld_rs    = 1'b0;
		ld_delay = sat_delay(rom_e.delay);
		ld_lone  = rom_e.lone;
		case (cmd.kind)
			CMD_TICK: begin
				case (phase_q)
					PH_POWER: begin
						if (wait_q != '0) begin
							n_wait = wait_q - 1'b1;
						end
						if (n_wait == '0) begin
							n_step = STEP_BITS'(1);
							load   = 1'b1;
						end
					end
					PH_SETUP: begin
						n_pin[5] = 1'b1;
						n_phase  = PH_EHIGH;
					end
					PH_EHIGH: begin
						n_pin[5] = 1'b0;
						n_phase  = PH_ELOW;
					end
					PH_ELOW: begin
						if (delay_q == '0) begin
							done = 1'b1;
						end else begin
							n_wait  = delay_q;
							n_phase = PH_DELAY;
						end
					end
					PH_DELAY: begin
						if (wait_q != '0) begin
							n_wait = wait_q - 1'b1;
						end
						if (n_wait == '0) begin
							done = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_WRITE: begin
				if (busy) begin
					n_rej = 1'b1;
				end else begin
					load     = 1'b1;
					ld_byte  = cmd.data_byte;
					ld_rs    = cmd.reg_select;
					ld_delay = sat_delay(cmd.delay_after_us);
					ld_lone  = 1'b0;
				end
			end
			CMD_INIT: begin
				if (busy) begin
					n_rej = 1'b1;
				end else begin
					n_wait = sat_delay(power_wait_q);
					n_step = STEP_BITS'(1);
					if (n_wait == '0) begin
						load = 1'b1;
					end else begin
						n_phase = PH_POWER;
					end
				end
			end
			default: begin
			end
		endcase

		// End of one nibble: low nibble next, next ROM entry, or finished.
		if (done) begin
			if (!low_q) begin
				n_low = 1'b1;
				drive = 1'b1;
			end else if (step_q != '0 && step_q < STEP_BITS'(INIT_ENTRIES)) begin
				load   = 1'b1;
				n_step = step_q + 1'b1;
			end else begin
				n_step  = '0;
				n_phase = PH_IDLE;
			end
		end

		if (load) begin
			n_byte  = ld_byte;
			n_rs    = ld_rs;
			n_delay = ld_delay;
			n_low   = ld_lone;
			drive   = 1'b1;
		end

		if (drive) begin
			n_pin   = {1'b0, n_rs, (n_low ? n_byte[3:0] : n_byte[7:4])};
			n_phase = PH_SETUP;
		end

		new_res.lcd_nibble = n_pin[3:0];
		new_res.lcd_rs     = n_pin[4];
		new_res.lcd_enable = n_pin[5];
		new_res.busy_res   = (n_phase != PH_IDLE);
		new_res.rejected   = n_rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			power_wait_q <= POWER_ON_WAIT_RESET;
			byte_q       <= '0;
			rs_q         <= 1'b0;
			delay_q      <= '0;
			low_q        <= 1'b0;
			wait_q       <= '0;
			step_q       <= '0;
			pin_q        <= '0;
		end else begin
			if (cfg_we) begin
				power_wait_q <= cfg_wdata;
			end
			if (cmd_take) begin
				phase_q <= n_phase;
				byte_q  <= n_byte;
				rs_q    <= n_rs;
				delay_q <= n_delay;
				low_q   <= n_low;
				wait_q  <= n_wait;
				step_q  <= n_step;
				pin_q   <= n_pin;
			end
		end
	end

	// Result queue toward the receiver.
	assign empty = (ocnt_q == '0);
	assign res   = omem_q[ord_q];
	assign opop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			omem_q[owr_q] <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (cmd_take) begin
				owr_q <= owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= ord_q + 1'b1;
			end
			if (cmd_take && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (opop && !cmd_take) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/char_lcd_4bit_write_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD 4-bit write sequencer
// Drives a character LCD bus from a stream of tick, write and init requests.
// ----------------------------------------------------------------------------
// Usage: requests enter through push/full and carry func, data_byte,
// reg_select and delay_after_us. A tick request advances time by one
// microsecond; write and init requests start a byte write or the init
// sequence, and are rejected while the sequencer is busy. Every request
// yields exactly one result, read through empty/pop, that shows the LCD
// lines, the busy flag and the reject flag after that request.
// A request passes the request queue and its result the result queue before the
// result is on the output ports. One request per clock is sustained while the
// receiver pops; two-entry queues sit before and after the sequencer.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, the request queue fills and full rises; nothing is lost.
// Reset empties both queues, clears the pin state, leaves the sequencer idle
// and sets the power-on wait to 1500 us. cfg_we/cfg_wdata writes the power-on
// wait; the user must use it only while the block is idle (the block does not enforce this).
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  data_byte,
	input  wire logic        reg_select,
	input  wire logic [15:0] delay_after_us,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       lcd_nibble,
	output logic             lcd_rs,
	output logic             lcd_enable,
	output logic             busy_res,
	output logic             rejected
);
	import clcd_pkg::*;

	logic    cmd_valid;
	logic    cmd_take;
	cmd_t    cmd;
	result_t res;

	clcd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.data_byte      (data_byte),
		.reg_select     (reg_select),
		.delay_after_us (delay_after_us),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_take       (cmd_take)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign lcd_nibble = res.lcd_nibble;
	assign lcd_rs     = res.lcd_rs;
	assign lcd_enable = res.lcd_enable;
	assign busy_res   = res.busy_res;
	assign rejected   = res.rejected;

	// A rejected request leaves the sequencer busy.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rejected) |-> busy_res)
		else $error("rejected request reported while not busy");

	// The enable strobe only rises inside a nibble transfer.
	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && lcd_enable) |-> busy_res)
		else $error("enable high while sequencer idle");

	// A queued request that the sequencer did not take is still queued.
	a_cmd_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_take) |=> cmd_valid)
		else $error("queued request lost between front and back");

endmodule
`default_nettype wire
